### hdl/ps2_mouse_device_macros.svh
// Assertion macros for the PS/2 mouse device checker.
`ifndef PS2_MOUSE_DEVICE_MACROS_SVH
`define PS2_MOUSE_DEVICE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ps2 mouse device: check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define PMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ps2 mouse device: check failed");

`endif

### hdl/ps2md_pkg.sv
// Shared constants and types for the PS/2 mouse device.
package ps2md_pkg;

  localparam int unsigned AccWidthDef = 16;
  localparam int unsigned MaxReply    = 4;
  localparam int unsigned ReplyCntW   = $clog2(MaxReply + 1);
  localparam int unsigned ReplyIdxW   = $clog2(MaxReply);

  // Host commands
  localparam logic [7:0] CMD_SCALE_1TO1  = 8'hE6;
  localparam logic [7:0] CMD_SCALE_2TO1  = 8'hE7;
  localparam logic [7:0] CMD_SET_RES     = 8'hE8;
  localparam logic [7:0] CMD_STATUS      = 8'hE9;
  localparam logic [7:0] CMD_READ_ID     = 8'hF2;
  localparam logic [7:0] CMD_SET_RATE    = 8'hF3;
  localparam logic [7:0] CMD_ENABLE      = 8'hF4;
  localparam logic [7:0] CMD_DISABLE     = 8'hF5;
  localparam logic [7:0] CMD_RESET       = 8'hFF;

  // Device replies
  localparam logic [7:0] RSP_ACK         = 8'hFA;
  localparam logic [7:0] RSP_SELF_TEST   = 8'hAA;
  localparam logic [7:0] RSP_DEVICE_ID   = 8'h00;
  localparam logic [7:0] PKT_ALWAYS_ONE  = 8'h08;

  localparam logic [3:0] QUEUE_LIMIT     = 4'd13;

  localparam logic KIND_HOST   = 1'b0;
  localparam logic KIND_MOTION = 1'b1;

  typedef struct packed {
    logic [MaxReply-1:0][7:0] bytes;  // bytes[0] goes out first
    logic [ReplyCntW-1:0]     count;
  } reply_t;

endpackage

### hdl/ps2md_core.sv
// Command decoder, device state and motion accumulators of the PS/2 mouse.
module ps2md_core
  import ps2md_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = AccWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               kind_i,
  input  logic [7:0]         host_byte_i,
  input  logic signed [11:0] delta_x_i,
  input  logic signed [11:0] delta_y_i,
  input  logic [2:0]         buttons_i,
  input  logic               reporting_allowed_i,
  input  logic [3:0]         queue_fill_i,
  output reply_t             reply_o
);

  localparam int unsigned SumW = ((ACC_WIDTH > 12) ? ACC_WIDTH : 12) + 2;
  localparam logic signed [SumW-1:0] AccMax = (SumW'(1) <<< (ACC_WIDTH - 1)) - SumW'(1);
  localparam logic signed [SumW-1:0] AccMin = -AccMax - SumW'(1);
  localparam logic signed [SumW-1:0] PktMax = SumW'(255);
  localparam logic signed [SumW-1:0] PktMin = -SumW'(256);

  logic                        enable_q, enable_d;
  logic                        scale_q, scale_d;
  logic [7:0]                  resolution_q, resolution_d;
  logic [7:0]                  sample_rate_q, sample_rate_d;
  logic [7:0]                  pending_q, pending_d;
  logic                        awaiting_q, awaiting_d;
  logic signed [ACC_WIDTH-1:0] acc_x_q, acc_x_d;
  logic signed [ACC_WIDTH-1:0] acc_y_q, acc_y_d;
  logic [2:0]                  last_btn_q, last_btn_d;

  logic signed [SumW-1:0]      sum_x, sum_y;
  logic signed [ACC_WIDTH-1:0] sat_x, sat_y;
  logic signed [SumW-1:0]      sat_x_ext, sat_y_ext;
  logic [8:0]                  pkt_x, pkt_y;
  logic                        idle_motion;

  always_comb begin
    sum_x = SumW'(acc_x_q) + SumW'(delta_x_i);
    sum_y = SumW'(acc_y_q) - SumW'(delta_y_i);

    if (sum_x > AccMax) begin
      sat_x = AccMax[ACC_WIDTH-1:0];
    end else if (sum_x < AccMin) begin
      sat_x = AccMin[ACC_WIDTH-1:0];
    end else begin
      sat_x = sum_x[ACC_WIDTH-1:0];
    end
    if (sum_y > AccMax) begin
      sat_y = AccMax[ACC_WIDTH-1:0];
    end else if (sum_y < AccMin) begin
      sat_y = AccMin[ACC_WIDTH-1:0];
    end else begin
      sat_y = sum_y[ACC_WIDTH-1:0];
    end

    sat_x_ext = SumW'(sat_x);
    sat_y_ext = SumW'(sat_y);
    if (sat_x_ext > PktMax) begin
      pkt_x = PktMax[8:0];
    end else if (sat_x_ext < PktMin) begin
      pkt_x = PktMin[8:0];
    end else begin
      pkt_x = sat_x_ext[8:0];
    end
    if (sat_y_ext > PktMax) begin
      pkt_y = PktMax[8:0];
    end else if (sat_y_ext < PktMin) begin
      pkt_y = PktMin[8:0];
    end else begin
      pkt_y = sat_y_ext[8:0];
    end

    idle_motion = (delta_x_i == '0) && (delta_y_i == '0) && (buttons_i == last_btn_q);
  end

  always_comb begin
    enable_d      = enable_q;
    scale_d       = scale_q;
    resolution_d  = resolution_q;
    sample_rate_d = sample_rate_q;
    pending_d     = pending_q;
    awaiting_d    = awaiting_q;
    acc_x_d       = acc_x_q;
    acc_y_d       = acc_y_q;
    last_btn_d    = last_btn_q;
    reply_o       = '0;

    if (kind_i == KIND_HOST) begin
      if (awaiting_q) begin
        awaiting_d = 1'b0;
        if (pending_q == CMD_SET_RES) begin
          resolution_d      = host_byte_i;
          reply_o.bytes[0]  = RSP_ACK;
          reply_o.count     = ReplyCntW'(1);
        end else if (pending_q == CMD_SET_RATE) begin
          sample_rate_d     = host_byte_i;
          reply_o.bytes[0]  = RSP_ACK;
          reply_o.count     = ReplyCntW'(1);
        end
      end else begin
        pending_d = host_byte_i;
        case (host_byte_i)
          CMD_SCALE_1TO1: begin
            scale_d          = 1'b0;
            reply_o.bytes[0] = RSP_ACK;
            reply_o.count    = ReplyCntW'(1);
          end
          CMD_SCALE_2TO1: begin
            scale_d          = 1'b1;
            reply_o.bytes[0] = RSP_ACK;
            reply_o.count    = ReplyCntW'(1);
          end
          CMD_SET_RES, CMD_SET_RATE: begin
            awaiting_d       = 1'b1;
            reply_o.bytes[0] = RSP_ACK;
            reply_o.count    = ReplyCntW'(1);
          end
          CMD_STATUS: begin
            reply_o.bytes[0] = RSP_ACK;
            reply_o.bytes[1] = {2'b00, enable_q, scale_q, 1'b0, buttons_i};
            reply_o.bytes[2] = resolution_q;
            reply_o.bytes[3] = sample_rate_q;
            reply_o.count    = ReplyCntW'(4);
          end
          CMD_READ_ID: begin
            reply_o.bytes[0] = RSP_ACK;
            reply_o.bytes[1] = RSP_DEVICE_ID;
            reply_o.count    = ReplyCntW'(2);
          end
          CMD_ENABLE: begin
            enable_d         = 1'b1;
            reply_o.bytes[0] = RSP_ACK;
            reply_o.count    = ReplyCntW'(1);
          end
          CMD_DISABLE: begin
            enable_d         = 1'b0;
            reply_o.bytes[0] = RSP_ACK;
            reply_o.count    = ReplyCntW'(1);
          end
          CMD_RESET: begin
            enable_d         = 1'b0;
            scale_d          = 1'b0;
            reply_o.bytes[0] = RSP_ACK;
            reply_o.bytes[1] = RSP_SELF_TEST;
            reply_o.bytes[2] = RSP_DEVICE_ID;
            reply_o.count    = ReplyCntW'(3);
          end
          default: begin
          end
        endcase
      end
    end else if (!idle_motion && reporting_allowed_i) begin
      acc_x_d = sat_x;
      acc_y_d = sat_y;
      if (enable_q && (queue_fill_i < QUEUE_LIMIT)) begin
        last_btn_d       = buttons_i;
        reply_o.bytes[0] = PKT_ALWAYS_ONE | {2'b00, pkt_y[8], pkt_x[8], 1'b0, buttons_i};
        reply_o.bytes[1] = pkt_x[7:0];
        reply_o.bytes[2] = pkt_y[7:0];
        reply_o.count    = ReplyCntW'(3);
        acc_x_d          = '0;
        acc_y_d          = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q      <= 1'b0;
      scale_q       <= 1'b0;
      resolution_q  <= '0;
      sample_rate_q <= '0;
      pending_q     <= '0;
      awaiting_q    <= 1'b0;
      acc_x_q       <= '0;
      acc_y_q       <= '0;
      last_btn_q    <= '0;
    end else if (accept_i) begin
      enable_q      <= enable_d;
      scale_q       <= scale_d;
      resolution_q  <= resolution_d;
      sample_rate_q <= sample_rate_d;
      pending_q     <= pending_d;
      awaiting_q    <= awaiting_d;
      acc_x_q       <= acc_x_d;
      acc_y_q       <= acc_y_d;
      last_btn_q    <= last_btn_d;
    end
  end

endmodule

### hdl/ps2md_txbuf.sv
// Reply register that sends the bytes of one item to the host one per cycle while out_ready_i is high.
module ps2md_txbuf
  import ps2md_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  reply_t     reply_i,
  input  logic       load_i,
  output logic       can_load_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o
);

  logic [MaxReply-1:0][7:0] bytes_q;
  logic [ReplyCntW-1:0]     cnt_q, cnt_d;
  logic [ReplyIdxW-1:0]     idx_q, idx_d;
  logic                     take;

  assign out_valid_o   = (cnt_q != '0);
  assign last_of_run_o = (cnt_q == ReplyCntW'(1));
  assign out_byte_o    = bytes_q[idx_q];
  assign take          = out_valid_o && out_ready_i;
  assign can_load_o    = !out_valid_o || (last_of_run_o && out_ready_i);

  always_comb begin
    cnt_d = cnt_q;
    idx_d = idx_q;
    if (load_i) begin
      cnt_d = reply_i.count;
      idx_d = '0;
    end else if (take) begin
      cnt_d = cnt_q - ReplyCntW'(1);
      idx_d = idx_q + ReplyIdxW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= reply_i.bytes;
    end
  end

endmodule

### hdl/ps2_mouse_device.sv
// Top level of the PS/2 mouse device: host command and motion items in, reply bytes out.
//
// Input channel (in_valid_i/in_ready_o): one item is a host byte (kind_i = 0) or a
// motion report (kind_i = 1). The item is decoded and the device state updated in the
// accepting cycle; its reply bytes (zero to four) are loaded into the reply register.
// Output channel (out_valid_o/out_ready_i): one reply byte per cycle while out_ready_i
// is high, first byte in the cycle after acceptance; last_of_run_o marks the final byte
// of an item. An item holds the reply register until its last byte is taken; an item
// with no reply bytes leaves it free. The next item is taken in the same cycle the last
// byte of the previous one leaves.
// A stalled receiver holds the current byte and the reply register, and in_ready_o
// stays low until the last byte is taken.
// Reset clears the flags, resolution, sample rate, accumulators and the reply byte count;
// the block accepts items as soon as reset is released.
module ps2_mouse_device
  import ps2md_pkg::*;
#(
  parameter int unsigned ACC_WIDTH = AccWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               kind_i,
  input  logic [7:0]         host_byte_i,
  input  logic signed [11:0] delta_x_i,
  input  logic signed [11:0] delta_y_i,
  input  logic [2:0]         buttons_i,
  input  logic               reporting_allowed_i,
  input  logic [3:0]         queue_fill_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         out_byte_o,
  output logic               last_of_run_o
);

  reply_t reply;
  logic   accept;
  logic   can_load;

  assign in_ready_o = can_load;
  assign accept     = in_valid_i && can_load;

  ps2md_core #(
    .ACC_WIDTH(ACC_WIDTH)
  ) u_core (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .kind_i             (kind_i),
    .host_byte_i        (host_byte_i),
    .delta_x_i          (delta_x_i),
    .delta_y_i          (delta_y_i),
    .buttons_i          (buttons_i),
    .reporting_allowed_i(reporting_allowed_i),
    .queue_fill_i       (queue_fill_i),
    .reply_o            (reply)
  );

  ps2md_txbuf u_txbuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .reply_i      (reply),
    .load_i       (accept),
    .can_load_o   (can_load),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .last_of_run_o(last_of_run_o)
  );

endmodule

### hdl/ps2md_checker.sv
// Port-level checks for the PS/2 mouse device and their bind to the top level.
`include "ps2_mouse_device_macros.svh"

module ps2md_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       last_of_run_o
);

  logic       out_stall;
  logic       mid_take;
  logic [8:0] out_word;

  assign out_stall = out_valid_o && !out_ready_i;
  assign mid_take  = out_valid_o && out_ready_i && !last_of_run_o;
  assign out_word  = {out_byte_o, last_of_run_o};

  // stalled byte holds
  `PMD_ASSERT_NEXT(a_out_hold, out_stall, out_valid_o && $stable(out_word))

  // input only taken once the current run is finishing
  `PMD_ASSERT_NOW(a_ready_at_run_end, in_ready_o, !out_valid_o || (last_of_run_o && out_ready_i))

  // nothing pending means free to take an item
  `PMD_ASSERT_NOW(a_idle_ready, !out_valid_o, in_ready_o)

  // a run does not stop before its last byte
  `PMD_ASSERT_NEXT(a_run_continues, mid_take, out_valid_o && (last_of_run_o || !in_ready_o))

endmodule

bind ps2_mouse_device ps2md_checker u_checker (.*);
